// File: rtl/core/hmss_pkg.sv
// ----------------------------------------------------------------------------
// Height map scale and smooth package
// Shared item types, register indexes, reset values and controller commands.
// ----------------------------------------------------------------------------
package hmss_pkg;

	typedef struct packed {
		logic       func;
		logic [7:0] height_byte;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] smoothed_height;
		logic [9:0]         out_row;
		logic [9:0]         out_col;
		logic               frame_done;
	} out_item_t;

	localparam logic [1:0] CFG_NUM_COLS      = 2'd0;
	localparam logic [1:0] CFG_NUM_ROWS      = 2'd1;
	localparam logic [1:0] CFG_HEIGHT_SCALE  = 2'd2;
	localparam logic [1:0] CFG_HEIGHT_OFFSET = 2'd3;

	localparam logic [10:0] NUM_COLS_RST      = 11'd513;
	localparam logic [10:0] NUM_ROWS_RST      = 11'd513;
	localparam logic [15:0] HEIGHT_SCALE_RST  = 16'd1434;
	localparam logic [15:0] HEIGHT_OFFSET_RST = 16'hFEC0;

	localparam int NUM_W = 21;
	localparam logic [4:0] DIV_STEPS = 5'd21;

	typedef struct packed {
		logic take;
		logic sum_en;
		logic zero_v;
		logic top_en;
		logic bot_en;
		logic left_en;
		logic right_en;
		logic div_step;
		logic out_load;
		logic frame_done;
	} cmd_t;

endpackage

// File: rtl/core/hmss_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hmss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/core/hmss_ctrl.sv
// ----------------------------------------------------------------------------
// Height map scale and smooth controller
// Raster position counters, output scheduling and the per-item sequence.
// ----------------------------------------------------------------------------
module hmss_ctrl #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [10:0]                 num_cols,
	input  logic [10:0]                 num_rows,
	input  logic                        in_valid,
	input  logic                        in_func,
	output logic                        in_ready,
	output hmss_pkg::cmd_t              cmd,
	output logic [$clog2(MAX_COLS)-1:0] rd_addr,
	output logic [$clog2(MAX_COLS)-1:0] wr_addr,
	output logic [9:0]                  pos_row,
	output logic [9:0]                  pos_col,
	input  logic                        out_busy
);

	localparam int AW  = $clog2(MAX_COLS);
	localparam int RW  = $clog2(MAX_ROWS);
	localparam int CNW = $clog2(MAX_COLS + 1);
	localparam int RNW = $clog2(MAX_ROWS + 1);
	localparam int PW  = $clog2(MAX_COLS + 2);

	typedef enum logic [1:0] {S_IDLE, S_SUM, S_DIV, S_OUT} state_t;

	state_t         state_q;
	logic [AW-1:0]  in_col_q, out_col_q, in_col_c, out_col_c;
	logic [RW-1:0]  in_row_q, out_row_q, in_row_c, out_row_c;
	logic [PW-1:0]  pend_q, pend_c;
	logic [CNW-1:0] ceff_q, ceff_c;
	logic [RNW-1:0] reff_q, reff_c;
	logic           drain_q;
	logic [4:0]     div_cnt_q;
	logic           accept, have, done;

	always_comb begin
		if (num_cols == 11'd0) begin
			ceff_c = CNW'(1);
		end else if (32'(num_cols) > 32'(MAX_COLS)) begin
			ceff_c = CNW'(MAX_COLS);
		end else begin
			ceff_c = CNW'(num_cols);
		end
		if (num_rows == 11'd0) begin
			reff_c = RNW'(1);
		end else if (32'(num_rows) > 32'(MAX_ROWS)) begin
			reff_c = RNW'(MAX_ROWS);
		end else begin
			reff_c = RNW'(num_rows);
		end
		in_col_c  = (32'(in_col_q) >= 32'(ceff_c)) ? '0 : in_col_q;
		out_col_c = (32'(out_col_q) >= 32'(ceff_c)) ? '0 : out_col_q;
		in_row_c  = (32'(in_row_q) >= 32'(reff_c)) ? '0 : in_row_q;
		out_row_c = (32'(out_row_q) >= 32'(reff_c)) ? '0 : out_row_q;
		pend_c    = (32'(pend_q) > 32'(ceff_c) + 1) ? PW'(32'(ceff_c) + 1) : pend_q;
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign have     = (32'(pend_q) == 32'(ceff_q) + 1);
	assign done     = (32'(out_row_q) + 1 == 32'(reff_q)) &&
		(32'(out_col_q) + 1 == 32'(ceff_q));
	assign rd_addr  = in_col_c;
	assign wr_addr  = in_col_q;
	assign pos_row  = 10'(out_row_q);
	assign pos_col  = 10'(out_col_q);

	always_comb begin
		cmd            = '0;
		cmd.take       = accept;
		cmd.sum_en     = (state_q == S_SUM);
		cmd.zero_v     = drain_q;
		cmd.top_en     = (out_row_q != '0);
		cmd.bot_en     = (32'(out_row_q) + 1 < 32'(reff_q));
		cmd.left_en    = (out_col_q != '0);
		cmd.right_en   = (in_col_q != '0) && (32'(out_col_q) + 1 < 32'(ceff_q));
		cmd.div_step   = (state_q == S_DIV);
		cmd.out_load   = (state_q == S_OUT) && !out_busy;
		cmd.frame_done = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			ceff_q    <= CNW'(1);
			reff_q    <= RNW'(1);
			drain_q   <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_col_q  <= in_col_c;
						in_row_q  <= in_row_c;
						out_col_q <= out_col_c;
						out_row_q <= out_row_c;
						pend_q    <= pend_c;
						ceff_q    <= ceff_c;
						reff_q    <= reff_c;
						if (drain_q || !in_func) begin
							state_q <= S_SUM;
						end
					end
				end
				S_SUM: begin
					if (!have) begin
						pend_q <= pend_q + PW'(1);
					end
					if (32'(in_col_q) + 1 >= 32'(ceff_q)) begin
						in_col_q <= '0;
						if (!drain_q) begin
							if (32'(in_row_q) + 1 >= 32'(reff_q)) begin
								in_row_q <= '0;
								drain_q  <= 1'b1;
							end else begin
								in_row_q <= in_row_q + RW'(1);
							end
						end
					end else begin
						in_col_q <= in_col_q + AW'(1);
					end
					div_cnt_q <= '0;
					state_q   <= have ? S_DIV : S_IDLE;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == hmss_pkg::DIV_STEPS - 5'd1) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
						if (done) begin
							in_col_q  <= '0;
							in_row_q  <= '0;
							out_col_q <= '0;
							out_row_q <= '0;
							pend_q    <= '0;
							drain_q   <= 1'b0;
						end else if (32'(out_col_q) + 1 >= 32'(ceff_q)) begin
							out_col_q <= '0;
							out_row_q <= (32'(out_row_q) + 1 >= 32'(reff_q)) ?
								'0 : out_row_q + RW'(1);
						end else begin
							out_col_q <= out_col_q + AW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/hmss_dp.sv
// ----------------------------------------------------------------------------
// Height map scale and smooth datapath
// Scaler, line stores, 3x3 window, neighborhood sum, divider and output register.
// ----------------------------------------------------------------------------
module hmss_dp #(
	parameter int MAX_COLS = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [15:0]                 height_scale,
	input  logic [15:0]                 height_offset,
	input  logic [7:0]                  height_byte,
	input  hmss_pkg::cmd_t              cmd,
	input  logic [$clog2(MAX_COLS)-1:0] rd_addr,
	input  logic [$clog2(MAX_COLS)-1:0] wr_addr,
	input  logic [9:0]                  pos_row,
	input  logic [9:0]                  pos_col,
	output logic                        out_busy,
	output logic                        out_valid,
	input  logic                        out_ready,
	output hmss_pkg::out_item_t         out_item
);

	localparam int NW = hmss_pkg::NUM_W;

	logic [7:0]         byte_q;
	logic [15:0]        above_rd, cur_rd;
	logic [15:0]        win_q [3][2];
	logic [15:0]        newv [3];
	logic [23:0]        prod;
	logic signed [17:0] ssum;
	logic [15:0]        scaled;
	logic [1:0]         nrows, ncols;
	logic [3:0]         n;
	logic [19:0]        sum;
	logic [NW-1:0]      num_q;
	logic [4:0]         rem_q, den_q;
	logic [5:0]         trial;
	logic               out_valid_q;

	hmss_ram #(.WIDTH(16), .DEPTH(MAX_COLS)) u_above (
		.clk(clk), .wr_en(cmd.sum_en), .wr_addr(wr_addr), .wr_data(cur_rd),
		.rd_en(cmd.take), .rd_addr(rd_addr), .rd_data(above_rd)
	);

	hmss_ram #(.WIDTH(16), .DEPTH(MAX_COLS)) u_current (
		.clk(clk), .wr_en(cmd.sum_en), .wr_addr(wr_addr), .wr_data(newv[2]),
		.rd_en(cmd.take), .rd_addr(rd_addr), .rd_data(cur_rd)
	);

	always_comb begin
		prod = 24'(byte_q) * 24'(height_scale) + 24'd128;
		ssum = $signed({2'b00, prod[23:8]}) + $signed({{2{height_offset[15]}}, height_offset});
		if (ssum > 18'sd32767) begin
			scaled = 16'h7FFF;
		end else if (ssum < -18'sd32768) begin
			scaled = 16'h8000;
		end else begin
			scaled = ssum[15:0];
		end
		newv[0] = above_rd;
		newv[1] = cur_rd;
		newv[2] = cmd.zero_v ? 16'h0000 : scaled;
	end

	always_comb begin
		nrows = 2'd1 + {1'b0, cmd.top_en} + {1'b0, cmd.bot_en};
		ncols = 2'd1 + {1'b0, cmd.left_en} + {1'b0, cmd.right_en};
		n     = {2'b00, nrows} * {2'b00, ncols};
		sum   = '0;
		for (int k = 0; k < 3; k++) begin
			if ((k == 1) || (k == 0 && cmd.top_en) || (k == 2 && cmd.bot_en)) begin
				sum = sum + 20'(win_q[k][1] ^ 16'h8000);
				if (cmd.left_en) begin
					sum = sum + 20'(win_q[k][0] ^ 16'h8000);
				end
				if (cmd.right_en) begin
					sum = sum + 20'(newv[k] ^ 16'h8000);
				end
			end
		end
		trial = {rem_q, num_q[NW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= '0;
				win_q[k][1] <= '0;
			end
		end else if (cmd.sum_en) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= newv[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= height_byte;
		end
		if (cmd.sum_en) begin
			num_q <= {sum, 1'b0} + NW'(n);
			den_q <= {n, 1'b0};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= 5'(trial - {1'b0, den_q});
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[4:0];
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_item.smoothed_height <= num_q[15:0] ^ 16'h8000;
			out_item.out_row         <= pos_row;
			out_item.out_col         <= pos_col;
			out_item.frame_done      <= cmd.frame_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_busy  = out_valid_q;

endmodule

// File: rtl/core/heightmap_scale_and_smooth_core.sv
// ----------------------------------------------------------------------------
// Height map scale and smooth core
// Scales raw height bytes to Q12.4 and replaces each by its 3x3 in-map mean.
// ----------------------------------------------------------------------------
// An ignored flush is accepted without leaving idle; an item that owes no result
// passes only through the sum step. An item with a result also runs the 21-step
// serial divider, and the next item is taken once the output register is free.
// Reset clears all counters and the window; the line stores are not cleared.
module heightmap_scale_and_smooth_core #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  hmss_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output hmss_pkg::out_item_t  out_item
);

	logic [10:0]           num_cols_q, num_rows_q;
	logic [15:0]           height_scale_q, height_offset_q;
	hmss_pkg::cmd_t        cmd;
	logic [$clog2(MAX_COLS)-1:0] rd_addr, wr_addr;
	logic [9:0]            pos_row, pos_col;
	logic                  out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q      <= hmss_pkg::NUM_COLS_RST;
			num_rows_q      <= hmss_pkg::NUM_ROWS_RST;
			height_scale_q  <= hmss_pkg::HEIGHT_SCALE_RST;
			height_offset_q <= hmss_pkg::HEIGHT_OFFSET_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hmss_pkg::CFG_NUM_COLS:      num_cols_q      <= cfg_wdata[10:0];
				hmss_pkg::CFG_NUM_ROWS:      num_rows_q      <= cfg_wdata[10:0];
				hmss_pkg::CFG_HEIGHT_SCALE:  height_scale_q  <= cfg_wdata;
				hmss_pkg::CFG_HEIGHT_OFFSET: height_offset_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hmss_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .num_cols(num_cols_q), .num_rows(num_rows_q),
		.in_valid(in_valid), .in_func(in_item.func), .in_ready(in_ready),
		.cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
		.pos_row(pos_row), .pos_col(pos_col), .out_busy(out_busy)
	);

	hmss_dp #(.MAX_COLS(MAX_COLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .height_scale(height_scale_q),
		.height_offset(height_offset_q), .height_byte(in_item.height_byte),
		.cmd(cmd), .rd_addr(rd_addr), .wr_addr(wr_addr),
		.pos_row(pos_row), .pos_col(pos_col), .out_busy(out_busy),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule
